[sv/elu_pkg.sv]
`timescale 1ns / 1ps

package elu_pkg;

    // Fixed fractional format of sample and alpha (Q3.12)
    localparam int FRAC_BITS = 12;
    // One table segment spans 1/8 of a unit
    localparam int SEG_SHIFT = FRAC_BITS - 3;
    // Interpolation fraction bits
    localparam int FRAC_W    = 8;
    // Segment index bits for the interior of the table
    localparam int IDX_W     = 6;
    // Index into the full table, one entry past the last segment
    localparam int TIDX_W    = 7;
    localparam int TAB_ENTRIES = 65;
    localparam int MAG_W     = 15;
    localparam int ALPHA_W   = 15;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 15'd4096;
    // Width of alpha*mag + rounding, and of the scaled result
    localparam int PROD_W    = ALPHA_W + MAG_W + 1;
    localparam int P_W       = PROD_W - MAG_W;

    // |exp(-k/8) - 1| in Q0.15, k = 0..64
    localparam logic [MAG_W-1:0] EXPM1_MAG [TAB_ENTRIES] = '{
        15'd0,     15'd3850,  15'd7248,  15'd10247, 15'd12893, 15'd15229,
        15'd17289, 15'd19108, 15'd20713, 15'd22130, 15'd23380, 15'd24483,
        15'd25456, 15'd26316, 15'd27074, 15'd27743, 15'd28333, 15'd28854,
        15'd29314, 15'd29720, 15'd30078, 15'd30394, 15'd30673, 15'd30919,
        15'd31137, 15'd31328, 15'd31497, 15'd31647, 15'd31778, 15'd31895,
        15'd31997, 15'd32088, 15'd32168, 15'd32238, 15'd32301, 15'd32356,
        15'd32404, 15'd32447, 15'd32485, 15'd32518, 15'd32547, 15'd32573,
        15'd32596, 15'd32616, 15'd32634, 15'd32650, 15'd32664, 15'd32676,
        15'd32687, 15'd32696, 15'd32705, 15'd32712, 15'd32719, 15'd32725,
        15'd32730, 15'd32734, 15'd32738, 15'd32742, 15'd32745, 15'd32747,
        15'd32750, 15'd32752, 15'd32754, 15'd32756, 15'd32757
    };

    // Stage load strobes handed to the term pipeline
    typedef struct packed {
        logic lookup;
        logic interp;
    } t_stage_ld;

endpackage

[sv/elu_activation_unit.sv]
`timescale 1ns / 1ps

// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+-----------
// input     | i_valid, o_ready, i_sample_in, i_last_in  | item in
// output    | o_valid, i_ready, o_sample_out, o_last_out| item out
// config    | i_cfg_valid, o_cfg_ready, i_cfg_data      | alpha write
//
// Five-stage pipeline: decode, table lookup, interpolation, alpha scale,
// negate/saturate. One item per cycle sustained while i_ready is high.
// Each stage holds a valid bit and advances when its successor is empty
// or advancing, so bubbles collapse under output backpressure.
// Reset (synchronous, active low) clears the valid bits and sets alpha = 1.0.
// o_cfg_ready is always high; write alpha only with pipe idle (not enforced).
module elu_activation_unit #(
    parameter int DATA_WIDTH     = 16,
    parameter int TABLE_SEGMENTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [DATA_WIDTH-1:0]  i_sample_in,
    input  logic                          i_last_in,
    // result items
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DATA_WIDTH-1:0]  o_sample_out,
    output logic                          o_last_out,
    // alpha register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [elu_pkg::ALPHA_W-1:0]   i_cfg_data
);
    import elu_pkg::*;

    localparam int TABLE_TOP = (TABLE_SEGMENTS < 64) ? TABLE_SEGMENTS : 64;
    // magnitude widened so segment/fraction selects exist at any width
    localparam int MX_W      = DATA_WIDTH + SEG_SHIFT;
    // saturation compare width
    localparam int CW        = ((DATA_WIDTH > P_W) ? DATA_WIDTH : P_W) + 1;
    localparam logic [CW-1:0] NEG_LIMIT = CW'(1) << (DATA_WIDTH - 1);

    // alpha register
    logic [ALPHA_W-1:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_valid) begin
            r_alpha <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // stage valids and advance chain
    logic [4:0] r_vld;
    logic [4:0] adv;

    always_comb begin
        adv[4] = !r_vld[4] || i_ready;
        adv[3] = !r_vld[3] || adv[4];
        adv[2] = !r_vld[2] || adv[3];
        adv[1] = !r_vld[1] || adv[2];
        adv[0] = !r_vld[0] || adv[1];
    end
    assign o_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
            if (adv[4]) r_vld[4] <= r_vld[3];
        end
    end

    // stage 1: magnitude, segment index, fraction
    logic [DATA_WIDTH-1:0] mag_in;
    logic [MX_W-1:0]       mag_x;
    logic [MX_W-1:0]       seg_full;
    logic                  n_s1_clamp;

    always_comb begin
        mag_in     = DATA_WIDTH'(~i_sample_in) + DATA_WIDTH'(1);
        mag_x      = {{SEG_SHIFT{1'b0}}, mag_in};
        seg_full   = mag_x >> SEG_SHIFT;
        n_s1_clamp = seg_full >= MX_W'(TABLE_TOP);
    end

    logic [DATA_WIDTH-1:0] r_s1_raw, r_s2_raw, r_s3_raw, r_s4_raw;
    logic [3:0]            r_last;
    logic                  r_s1_clamp;
    logic [IDX_W-1:0]      r_s1_idx;
    logic [FRAC_W-1:0]     r_s1_frac;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_raw   <= i_sample_in;
            r_last[0]  <= i_last_in;
            r_s1_clamp <= n_s1_clamp;
            r_s1_idx   <= mag_x[SEG_SHIFT+IDX_W-1:SEG_SHIFT];
            r_s1_frac  <= mag_x[SEG_SHIFT-1:SEG_SHIFT-FRAC_W];
        end
        if (adv[1]) begin
            r_s2_raw  <= r_s1_raw;
            r_last[1] <= r_last[0];
        end
        if (adv[2]) begin
            r_s3_raw  <= r_s2_raw;
            r_last[2] <= r_last[1];
        end
        if (adv[3]) begin
            r_s4_raw  <= r_s3_raw;
            r_last[3] <= r_last[2];
        end
    end

    // stages 2 and 3: table term
    t_stage_ld          term_ld;
    logic [MAG_W-1:0]   term_mag;

    assign term_ld.lookup = adv[1];
    assign term_ld.interp = adv[2];

    elu_expm1 #(
        .TABLE_TOP (TABLE_TOP)
    ) u_expm1 (
        .i_clk   (i_clk),
        .i_ld    (term_ld),
        .i_clamp (r_s1_clamp),
        .i_idx   (r_s1_idx),
        .i_frac  (r_s1_frac),
        .o_mag   (term_mag)
    );

    // stage 4: alpha scale, round half up
    logic [PROD_W-1:0] prod;
    logic [P_W-1:0]    r_s4_p;

    assign prod = PROD_W'(r_alpha) * PROD_W'(term_mag)
                  + PROD_W'(1 << (MAG_W - 1));

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_p <= prod[PROD_W-1:MAG_W];
        end
    end

    // stage 5: negate with saturation, or pass a non-negative sample
    logic [CW-1:0]         p_x;
    logic [CW-1:0]         p_sat;
    logic [CW-1:0]         neg_x;
    logic [DATA_WIDTH-1:0] n_res;
    logic [DATA_WIDTH-1:0] r_res;
    logic                  r_res_last;

    always_comb begin
        p_x   = CW'(r_s4_p);
        p_sat = (p_x > NEG_LIMIT) ? NEG_LIMIT : p_x;
        neg_x = ~p_sat + CW'(1);
        if (r_s4_raw[DATA_WIDTH-1]) begin
            n_res = neg_x[DATA_WIDTH-1:0];
        end else begin
            n_res = r_s4_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_res      <= n_res;
            r_res_last <= r_last[3];
        end
    end

    assign o_valid      = r_vld[4];
    assign o_sample_out = r_res;
    assign o_last_out   = r_res_last;

endmodule

[sv/elu_expm1.sv]
`timescale 1ns / 1ps

// Two-stage table lookup and linear interpolation of |exp(x)-1|.
module elu_expm1 #(
    parameter int TABLE_TOP = 64
) (
    input  logic                        i_clk,
    input  elu_pkg::t_stage_ld          i_ld,
    input  logic                        i_clamp,
    input  logic [elu_pkg::IDX_W-1:0]   i_idx,
    input  logic [elu_pkg::FRAC_W-1:0]  i_frac,
    output logic [elu_pkg::MAG_W-1:0]   o_mag
);
    import elu_pkg::*;

    localparam logic [TIDX_W-1:0] TOP_IDX = TIDX_W'(TABLE_TOP);

    logic [MAG_W-1:0]  r_lo, n_lo;
    logic [MAG_W-1:0]  r_diff, n_diff;
    logic [FRAC_W-1:0] r_frac;
    logic [MAG_W-1:0]  r_mag, n_mag;

    logic [TIDX_W-1:0] lo_idx;
    logic [TIDX_W-1:0] hi_idx;
    logic [MAG_W+FRAC_W-1:0] step;

    // lookup: past the table end the term is flat at the last entry
    always_comb begin
        lo_idx = {1'b0, i_idx};
        hi_idx = lo_idx + TIDX_W'(1);
        if (i_clamp) begin
            n_lo   = EXPM1_MAG[TOP_IDX];
            n_diff = '0;
        end else begin
            n_lo   = EXPM1_MAG[lo_idx];
            n_diff = EXPM1_MAG[hi_idx] - EXPM1_MAG[lo_idx];
        end
    end

    // interpolation, rounded to nearest
    always_comb begin
        step  = r_diff * {{MAG_W{1'b0}}, r_frac}
                + (MAG_W+FRAC_W)'(1 << (FRAC_W - 1));
        n_mag = r_lo + step[MAG_W+FRAC_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.lookup) begin
            r_lo   <= n_lo;
            r_diff <= n_diff;
            r_frac <= i_frac;
        end
        if (i_ld.interp) begin
            r_mag  <= n_mag;
        end
    end

    assign o_mag = r_mag;

endmodule
